// ===== hw/rtl/spne_pkg.sv =====
package spne_pkg;

  // Most encoded bytes that one input byte can release.
  localparam int unsigned MaxOut = 5;

  // Width of the maximum length register.
  localparam int unsigned MaxLenW = 10;

  // Configuration register indexes.
  localparam logic CfgEncodeDirs = 1'b0;
  localparam logic CfgMaxLength  = 1'b1;

  // Configuration reset values.
  localparam logic               EncodeDirsRst = 1'b1;
  localparam logic [MaxLenW-1:0] MaxLengthRst  = 10'd120;

  // Bytes 0..127 that pass through unchanged, bit n for byte n.
  localparam logic [127:0] PlainMask = {32'h2fffffff, 32'h68000001, 32'h2bff3bfa, 32'h00000001};

  // Bytes 64..95 that fold to an underscore pair, bit n for byte 64 + n.
  localparam logic [31:0] FoldMask = 32'h87fffffe;

  localparam logic [7:0] ChTilde = 8'h7e;

  // Encoded bytes released by one input byte, first byte in the lowest lane.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [2:0]             num;
    logic                   done;
    logic                   too_long;
  } res_t;

  function automatic logic is_plain(logic [7:0] c);
    return !c[7] && PlainMask[c[6:0]];
  endfunction

  function automatic logic is_fold(logic [7:0] c);
    return (c[7:5] == 3'd2) && FoldMask[c[4:0]];
  endfunction

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_char(logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'h0, d};
    end else begin
      r = 8'h57 + {4'h0, d};
    end
    return r;
  endfunction

  // Tilde and two hex digits, tilde in lane 0.
  function automatic logic [2:0][7:0] esc_bytes(logic [7:0] b);
    logic [2:0][7:0] r;
    r[0] = ChTilde;
    r[1] = hex_char(b[7:4]);
    r[2] = hex_char(b[3:0]);
    return r;
  endfunction

endpackage

// ===== hw/rtl/spne_core.sv =====
module spne_core #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  in_byte_i,
  input  logic                        encode_dirs_i,
  input  logic [spne_pkg::MaxLenW-1:0] max_length_i,
  input  logic                        res_free_i,
  output logic                        res_valid_o,
  output spne_pkg::res_t              res_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > spne_pkg::MaxLenW) ? COUNT_WIDTH
                                                                    : spne_pkg::MaxLenW;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChC     = 8'h63;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChG     = 8'h67;
  localparam logic [7:0] ChH     = 8'h68;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChL     = 8'h6c;
  localparam logic [7:0] ChM     = 8'h6d;
  localparam logic [7:0] ChN     = 8'h6e;
  localparam logic [7:0] ChO     = 8'h6f;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChX     = 8'h78;

  typedef enum logic [4:0] {
    ScStart, ScA, ScAu, ScThird, ScC, ScCo, ScComLpt, ScComLptN, ScL, ScLp,
    ScN, ScNu, ScP, ScPr, ScLdot, ScDot, ScH, ScHgdi, ScSpace, ScDefault
  } scan_e;

  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  scan_e                  scan_q, scan_d;
  logic [7:0]             held1_q, held1_d;
  logic [7:0]             held2_q, held2_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;

  logic [7:0]       c;
  logic             term_c;
  logic [3:0][7:0]  pre;
  logic [2:0]       pre_n;
  logic [2:0][7:0]  body;
  logic [1:0]       body_n;
  logic             redo;
  logic [55:0]      merged;
  logic [2:0]       num;
  logic [2:0]       nz;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] count_sat;
  logic             advance;

  assign c      = in_byte_q;
  assign term_c = (c == ChDot) || (c == ChSlash) || (c == ChNul);

  // Recognizer step: a prefix from the current state, then the body rule
  // when the state hands the byte on.
  always_comb begin
    pre     = '0;
    pre_n   = '0;
    body    = '0;
    body_n  = '0;
    redo    = 1'b0;
    scan_d  = scan_q;
    held1_d = held1_q;
    held2_d = held2_q;
    unique case (scan_q)
      ScStart: begin
        if (c == ChSlash) begin
          pre[0] = c;
          pre_n  = 3'd1;
        end else if (c == ChDot) begin
          pre[2:0] = spne_pkg::esc_bytes(c);
          pre_n    = 3'd3;
          scan_d   = ScLdot;
        end else if (c == ChSpace) begin
          pre[2:0] = spne_pkg::esc_bytes(c);
          pre_n    = 3'd3;
          scan_d   = ScDefault;
        end else if (c == ChA || c == ChC || c == ChL || c == ChN || c == ChP) begin
          pre[0] = c;
          pre_n  = 3'd1;
          if (c == ChA) begin
            scan_d = ScA;
          end else if (c == ChC) begin
            scan_d = ScC;
          end else if (c == ChL) begin
            scan_d = ScL;
          end else if (c == ChN) begin
            scan_d = ScN;
          end else begin
            scan_d = ScP;
          end
        end else begin
          redo = 1'b1;
        end
      end
      ScA, ScC, ScL, ScN, ScP, ScH: begin
        redo = 1'b1;
        if (scan_q == ScA && c == ChU) begin
          redo = 1'b0; scan_d = ScAu;
        end else if (scan_q == ScC && c == ChO) begin
          redo = 1'b0; scan_d = ScCo;
        end else if (scan_q == ScL && c == ChP) begin
          redo = 1'b0; scan_d = ScLp;
        end else if (scan_q == ScN && c == ChU) begin
          redo = 1'b0; scan_d = ScNu;
        end else if (scan_q == ScP && c == ChR) begin
          redo = 1'b0; scan_d = ScPr;
        end else if (scan_q == ScH && c == ChG) begin
          redo = 1'b0; scan_d = ScHgdi;
        end
        if (!redo) begin
          pre[0] = c;
          pre_n  = 3'd1;
        end
      end
      ScAu, ScNu, ScPr, ScLp, ScCo: begin
        // Third letter of a reserved name is held back until the next byte.
        redo = 1'b1;
        if ((scan_q == ScAu && c == ChX) || (scan_q == ScNu && c == ChL) ||
            (scan_q == ScPr && c == ChN) || (scan_q == ScCo && c == ChN)) begin
          redo    = 1'b0;
          held1_d = c;
          scan_d  = ScThird;
        end else if ((scan_q == ScLp && c == ChT) || (scan_q == ScCo && c == ChM)) begin
          redo    = 1'b0;
          held1_d = c;
          scan_d  = ScComLpt;
        end
      end
      ScThird: begin
        redo = 1'b1;
        if (term_c) begin
          pre[2:0] = spne_pkg::esc_bytes(held1_q);
          pre_n    = 3'd3;
        end else begin
          pre[0] = held1_q;
          pre_n  = 3'd1;
        end
      end
      ScComLpt: begin
        if (c >= ChOne && c <= ChNine) begin
          held2_d = c;
          scan_d  = ScComLptN;
        end else begin
          pre[0] = held1_q;
          pre_n  = 3'd1;
          redo   = 1'b1;
        end
      end
      ScComLptN: begin
        redo = 1'b1;
        if (term_c) begin
          pre[2:0] = spne_pkg::esc_bytes(held1_q);
          pre[3]   = held2_q;
          pre_n    = 3'd4;
        end else begin
          pre[0] = held1_q;
          pre[1] = held2_q;
          pre_n  = 3'd2;
        end
      end
      ScLdot: begin
        if (c == ChD || c == ChI) begin
          pre[0] = c;
          pre_n  = 3'd1;
          scan_d = ScHgdi;
        end else if (c == ChH) begin
          pre[0] = c;
          pre_n  = 3'd1;
          scan_d = ScH;
        end else begin
          redo = 1'b1;
        end
      end
      ScDot: begin
        if (c == ChSlash || c == ChNul) begin
          pre[2:0] = spne_pkg::esc_bytes(ChDot);
          pre[3]   = c;
          pre_n    = 3'd4;
          scan_d   = ScStart;
        end else if (c == ChD || c == ChI || c == ChH) begin
          pre[0] = ChDot;
          pre[1] = c;
          pre_n  = 3'd2;
          scan_d = (c == ChH) ? ScH : ScHgdi;
        end else begin
          pre[0] = ChDot;
          pre_n  = 3'd1;
          redo   = 1'b1;
        end
      end
      ScHgdi: begin
        if (c == ChSlash) begin
          scan_d = ScStart;
          if (encode_dirs_i) begin
            pre[0] = ChDot;
            pre[1] = ChH;
            pre[2] = ChG;
            pre[3] = c;
            pre_n  = 3'd4;
          end else begin
            pre[0] = c;
            pre_n  = 3'd1;
          end
        end else begin
          redo = 1'b1;
        end
      end
      ScSpace: begin
        if (c == ChSlash || c == ChNul) begin
          pre[2:0] = spne_pkg::esc_bytes(ChSpace);
          pre[3]   = c;
          pre_n    = 3'd4;
          scan_d   = ScStart;
        end else begin
          pre[0] = ChSpace;
          pre_n  = 3'd1;
          redo   = 1'b1;
        end
      end
      default: begin
        redo = 1'b1;
      end
    endcase

    // Component body rule.
    if (redo) begin
      scan_d = ScDefault;
      priority if (spne_pkg::is_plain(c)) begin
        body[0] = c;
        body_n  = 2'd1;
      end else if (c == ChDot) begin
        scan_d = ScDot;
      end else if (c == ChSpace) begin
        scan_d = ScSpace;
      end else if (c == ChSlash) begin
        body[0] = c;
        body_n  = 2'd1;
        scan_d  = ScStart;
      end else if (spne_pkg::is_fold(c)) begin
        body[0] = ChUnder;
        body[1] = (c == ChUnder) ? ChUnder : c + 8'h20;
        body_n  = 2'd2;
      end else begin
        body   = spne_pkg::esc_bytes(c);
        body_n = 2'd3;
      end
    end

    // The terminator starts a fresh path.
    if (c == ChNul) begin
      scan_d  = ScStart;
      held1_d = '0;
      held2_d = '0;
    end
  end

  // Append the body bytes behind the prefix.
  assign merged = 56'(pre) | (56'(body) << {pre_n, 3'b000});
  assign num    = pre_n + {1'b0, body_n};

  // Saturating length count; only the terminator is a zero byte.
  assign nz        = num - {2'b00, (c == ChNul)};
  assign sum       = {1'b0, count_q} + (COUNT_WIDTH + 1)'(nz);
  assign count_sat = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
  assign count_d   = (c == ChNul) ? '0 : count_sat;

  // An item that releases nothing moves on even while the output drains.
  assign advance    = in_valid_q && ((num == 3'd0) || res_free_i);
  assign in_ready_o = !in_valid_q || advance;

  assign res_valid_o    = advance && (num != 3'd0);
  assign res_o.bytes    = merged[8*spne_pkg::MaxOut-1:0];
  assign res_o.num      = num;
  assign res_o.done     = (c == ChNul);
  assign res_o.too_long = (c == ChNul) &&
                          (CmpW'(count_sat) > CmpW'(max_length_i));

  // Input register and recognizer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      scan_q     <= ScStart;
      held1_q    <= '0;
      held2_q    <= '0;
      count_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        scan_q  <= scan_d;
        held1_q <= held1_d;
        held2_q <= held2_d;
        count_q <= count_d;
      end
    end
  end

  // Input byte payload.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

endmodule

// ===== hw/rtl/spne_obuf.sv =====
module spne_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  spne_pkg::res_t res_i,
  output logic           res_free_o,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,  // out_byte
  output logic           m_axis_tlast,  // last_of_run
  output logic [1:0]     m_axis_tuser   // [0] path_done, [1] too_long
);

  logic [spne_pkg::MaxOut-1:0][7:0] bytes_q;
  logic [2:0]                       rem_q;
  logic                             done_q;
  logic                             too_long_q;
  logic                             last;
  logic                             take;

  assign last = (rem_q == 3'd1);
  assign take = m_axis_tvalid && m_axis_tready;

  // Free when empty or when the last byte leaves in this cycle.
  assign res_free_o = (rem_q == 3'd0) || (take && last);

  assign m_axis_tvalid = (rem_q != 3'd0);
  assign m_axis_tdata  = bytes_q[0];
  assign m_axis_tlast  = last;
  assign m_axis_tuser  = {too_long_q && last, done_q && last};

  // Remaining byte count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (res_valid_i) begin
      rem_q <= res_i.num;
    end else if (take) begin
      rem_q <= rem_q - 3'd1;
    end
  end

  // Byte shift register, one byte leaves per transaction.
  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      bytes_q    <= res_i.bytes;
      done_q     <= res_i.done;
      too_long_q <= res_i.too_long;
    end else if (take) begin
      bytes_q <= {8'h00, bytes_q[spne_pkg::MaxOut-1:1]};
    end
  end

endmodule

// ===== hw/rtl/store_path_name_encoder.sv =====
// Store path name encoder: takes a path one byte per transaction on the
// s_axis side, a zero byte ending the path, and streams the escaped encoding
// on the m_axis side, one byte per transaction, with tlast on the last byte
// that each input byte releases and path_done/too_long in tuser on the
// emitted terminator. An input byte passes an input register, is encoded
// combinationally and lands in a five-byte output shift register; the block
// sustains one input byte per cycle while each byte releases at most one
// output byte and m_axis_tready stays high. A byte that expands to N bytes
// (up to 5) holds the input while the shift register drains, one byte a
// cycle while m_axis_tready is high; a withheld byte (part of a possible
// reserved name) releases nothing and moves on even while the output drains.
// Configuration (index 0 encode_dirs, index 1 max_length) is for the user to
// write only while idle, not enforced by the block; a write is always accepted.
module store_path_name_encoder #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic       m_axis_tlast,   // last_of_run
  output logic [1:0] m_axis_tuser,   // [0] path_done, [1] too_long
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [spne_pkg::MaxLenW-1:0] cfg_data_i
);

  logic                         encode_dirs_q;
  logic [spne_pkg::MaxLenW-1:0] max_length_q;
  logic                         res_valid;
  logic                         res_free;
  spne_pkg::res_t               res;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encode_dirs_q <= spne_pkg::EncodeDirsRst;
      max_length_q  <= spne_pkg::MaxLengthRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        spne_pkg::CfgEncodeDirs: encode_dirs_q <= cfg_data_i[0];
        spne_pkg::CfgMaxLength:  max_length_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spne_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .encode_dirs_i(encode_dirs_q),
    .max_length_i (max_length_q),
    .res_free_i   (res_free),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  spne_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .res_free_o   (res_free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
